@@ hdl/dcma_pkg.sv @@
// shared constants and types for the dual channel moving average
package dcma_pkg;

    localparam int WINDOW     = 100;
    localparam int SAMPLE_W   = 12;
    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam int ENTRY_W    = 2 * SAMPLE_W;
    localparam int SUM_W      = $clog2(SAMPLE_MAX * WINDOW + 1);
    localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // floor(x / WINDOW) as (x * DIV_MULT) >> DIV_SHIFT, exact for any SUM_W-bit x
    localparam int    DIV_SHIFT    = SUM_W + $clog2(WINDOW);
    localparam int    MULT_W       = SUM_W + 1;
    localparam int    PROD_W       = SUM_W + MULT_W;
    localparam longint DIV_MULT_L  = ((64'(1) << DIV_SHIFT) + WINDOW - 1) / WINDOW;
    localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'(DIV_MULT_L);

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
    localparam int INFLIGHT_W = 2;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] voltage_total;
        logic [SUM_W-1:0] current_total;
    } dcma_sum_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] voltage_average;
        logic [SAMPLE_W-1:0] current_average;
    } dcma_avg_t;

endpackage

@@ hdl/dcma_sample_if.sv @@
// sample pair channel
interface dcma_sample_if import dcma_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] voltage_sample;
    logic [SAMPLE_W-1:0] current_sample;

    modport source (output valid, output voltage_sample, output current_sample, input ready);
    modport sink   (input valid, input voltage_sample, input current_sample, output ready);
endinterface

@@ hdl/dcma_average_if.sv @@
// average pair channel
interface dcma_average_if import dcma_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] voltage_average;
    logic [SAMPLE_W-1:0] current_average;

    modport source (output valid, output voltage_average, output current_average, input ready);
    modport sink   (input valid, input voltage_average, input current_average, output ready);
endinterface

@@ hdl/dcma_ram.sv @@
// generic single write port ram with registered read
module dcma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hdl/dcma_ring.sv @@
// sample rings in ram plus running window sums
module dcma_ring import dcma_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [SAMPLE_W-1:0] voltage_sample,
    input  logic [SAMPLE_W-1:0] current_sample,
    output dcma_sum_t           sums
);
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [WINDOW-1:0]  written_reg, written_next;
    logic               s1_valid_reg;
    logic [SLOT_W-1:0]  s1_slot_reg;
    logic [ENTRY_W-1:0] s1_entry_reg;
    logic               hit_reg;
    logic [ENTRY_W-1:0] hit_data_reg;
    logic               seen_reg;
    logic               sum_valid_reg;
    logic [SUM_W-1:0]   vtot_reg, vtot_next;
    logic [SUM_W-1:0]   ctot_reg, ctot_next;
    logic [ENTRY_W-1:0] ram_q;
    logic [ENTRY_W-1:0] old_entry;
    logic               hit;

    dcma_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW)
    ) u_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_slot_reg),
        .wdata (s1_entry_reg),
        .raddr (slot_reg),
        .rdata (ram_q)
    );

    // same slot written by the previous request (single-entry window)
    assign hit = s1_valid_reg && (s1_slot_reg == slot_reg);

    always_comb
    begin
        slot_next = slot_reg;
        if (accept)
        begin
            if (slot_reg == SLOT_W'(WINDOW - 1))
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_reg + SLOT_W'(1);
            end
        end
    end

    always_comb
    begin
        if (hit_reg)
        begin
            old_entry = hit_data_reg;
        end
        else if (seen_reg)
        begin
            old_entry = ram_q;
        end
        else
        begin
            old_entry = '0;
        end
    end

    always_comb
    begin
        written_next = written_reg;
        vtot_next    = vtot_reg;
        ctot_next    = ctot_reg;
        if (s1_valid_reg)
        begin
            written_next[s1_slot_reg] = 1'b1;
            vtot_next = vtot_reg - SUM_W'(old_entry[ENTRY_W-1:SAMPLE_W])
                        + SUM_W'(s1_entry_reg[ENTRY_W-1:SAMPLE_W]);
            ctot_next = ctot_reg - SUM_W'(old_entry[SAMPLE_W-1:0])
                        + SUM_W'(s1_entry_reg[SAMPLE_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            written_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            sum_valid_reg <= 1'b0;
            vtot_reg      <= '0;
            ctot_reg      <= '0;
        end
        else
        begin
            slot_reg      <= slot_next;
            written_reg   <= written_next;
            s1_valid_reg  <= accept;
            hit_reg       <= hit;
            seen_reg      <= written_reg[slot_reg];
            sum_valid_reg <= s1_valid_reg;
            vtot_reg      <= vtot_next;
            ctot_reg      <= ctot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_slot_reg  <= slot_reg;
        s1_entry_reg <= {voltage_sample, current_sample};
        hit_data_reg <= s1_entry_reg;
    end

    assign sums.valid         = sum_valid_reg;
    assign sums.voltage_total = vtot_reg;
    assign sums.current_total = ctot_reg;
endmodule

@@ hdl/dcma_div.sv @@
// divide both window sums by the window length via reciprocal multiply
module dcma_div import dcma_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  dcma_sum_t sums,
    output logic      push,
    output dcma_avg_t avg
);
    logic              valid_reg;
    logic [PROD_W-1:0] vprod_reg;
    logic [PROD_W-1:0] cprod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= sums.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        vprod_reg <= PROD_W'(sums.voltage_total) * PROD_W'(DIV_MULT);
        cprod_reg <= PROD_W'(sums.current_total) * PROD_W'(DIV_MULT);
    end

    assign push                = valid_reg;
    assign avg.voltage_average = vprod_reg[DIV_SHIFT +: SAMPLE_W];
    assign avg.current_average = cprod_reg[DIV_SHIFT +: SAMPLE_W];
endmodule

@@ hdl/dcma_fifo.sv @@
// output queue for finished averages
module dcma_fifo import dcma_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  dcma_avg_t             push_data,
    input  logic                  pop,
    output logic                  not_empty,
    output dcma_avg_t             head,
    output logic [FIFO_CNT_W-1:0] count
);
    dcma_avg_t               entries [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                    do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = entries[rd_ptr_reg];
    assign count     = count_reg;
endmodule

@@ hdl/dual_channel_moving_average.sv @@
// top level of the dual channel boxcar moving average
//
//  port      | dir | payload                          | request moves
//  samples   | in  | voltage_sample, current_sample   | one 12-bit sample pair
//  averages  | out | voltage_average, current_average | one 12-bit average pair
//
// one request per cycle while samples.ready is high; a result reaches the output queue
// through the ring ram read, running sum update and reciprocal multiply
// reset clears sums and the per-entry written flags, so unwritten ring entries read as zero
// the input is held off only when queued results plus requests in flight fill the
// eight-entry output queue
module dual_channel_moving_average import dcma_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    dcma_sample_if.sink   samples,
    dcma_average_if.source averages
);
    logic                  in_acc;
    logic                  push;
    logic                  pop;
    dcma_sum_t             sums;
    dcma_avg_t             avg;
    dcma_avg_t             head;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [INFLIGHT_W-1:0] inflight_reg, inflight_next;
    logic [FIFO_CNT_W:0]   credit_used;

    assign credit_used   = (FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(inflight_reg);
    assign samples.ready = (credit_used < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
    assign in_acc        = samples.valid && samples.ready;
    assign pop           = averages.valid && averages.ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_acc && !push)
        begin
            inflight_next = inflight_reg + INFLIGHT_W'(1);
        end
        else if (!in_acc && push)
        begin
            inflight_next = inflight_reg - INFLIGHT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    dcma_ring u_ring (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (in_acc),
        .voltage_sample (samples.voltage_sample),
        .current_sample (samples.current_sample),
        .sums           (sums)
    );

    dcma_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .sums  (sums),
        .push  (push),
        .avg   (avg)
    );

    dcma_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (avg),
        .pop       (pop),
        .not_empty (averages.valid),
        .head      (head),
        .count     (fifo_count)
    );

    assign averages.voltage_average = head.voltage_average;
    assign averages.current_average = head.current_average;

`ifndef SYNTHESIS
    // every accepted request is pushed into the queue after the ring and divider registers
    a_accept_to_push: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> ##3 push)
        else $error("accepted sample pair did not reach the output queue");

    // a push into the queue comes only from an earlier request
    a_push_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> $past(in_acc, 3))
        else $error("output queue push without a matching request");

    // credit scheme keeps the queue from overflowing
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fifo_count < FIFO_CNT_W'(FIFO_DEPTH)) || pop)
        else $error("output queue overflow");

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_used <= (FIFO_CNT_W + 1)'(FIFO_DEPTH))
        else $error("queued plus in-flight results exceed queue depth");
`endif
endmodule

@@ verif/dcma_window_checker.sv @@
// running-sum predictor and average pair scoreboard for the moving average block
`timescale 1ns / 1ps
module dcma_window_checker import dcma_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    dcma_sample_if  samples,
    dcma_average_if averages,
    output int      fail_count,
    output int      pending_count,
    output int      request_count,
    output int      result_count
);

    logic [SAMPLE_W-1:0] voltage_window [WINDOW];
    logic [SAMPLE_W-1:0] current_window [WINDOW];
    logic [SUM_W-1:0]    voltage_acc;
    logic [SUM_W-1:0]    current_acc;
    int                  oldest_slot;
    dcma_avg_t           expected_averages [$];

    // replace the oldest entry of each window and return the new floor averages
    task automatic advance_windows(input  logic [SAMPLE_W-1:0] voltage,
                                   input  logic [SAMPLE_W-1:0] current,
                                   output dcma_avg_t           averaged);
        // the sums may dip below zero mid-expression but the result always fits
        voltage_acc = voltage_acc - voltage_window[oldest_slot] + voltage;
        current_acc = current_acc - current_window[oldest_slot] + current;
        voltage_window[oldest_slot] = voltage;
        current_window[oldest_slot] = current;
        oldest_slot = (oldest_slot + 1) % WINDOW;
        averaged.voltage_average = SAMPLE_W'(voltage_acc / WINDOW);
        averaged.current_average = SAMPLE_W'(current_acc / WINDOW);
    endtask

    always @(posedge clk)
    begin
        dcma_avg_t predicted;
        dcma_avg_t oldest;
        int        errors;
        if (!rst_n)
        begin
            foreach (voltage_window[i])
            begin
                voltage_window[i] = '0;
                current_window[i] = '0;
            end
            voltage_acc   = '0;
            current_acc   = '0;
            oldest_slot   = 0;
            expected_averages.delete();
            fail_count    <= 0;
            pending_count <= 0;
            request_count <= 0;
            result_count  <= 0;
        end
        else
        begin
            errors = 0;
            if (samples.valid && samples.ready)
            begin
                advance_windows(samples.voltage_sample, samples.current_sample, predicted);
                expected_averages.push_back(predicted);
                request_count <= request_count + 1;
            end
            if (averages.valid && averages.ready)
            begin
                result_count <= result_count + 1;
                if (expected_averages.size() == 0)
                begin
                    $display("%0t: average pair expected none, actual %0d/%0d",
                             $time, averages.voltage_average, averages.current_average);
                    errors++;
                end
                else
                begin
                    oldest = expected_averages.pop_front();
                    if (averages.voltage_average !== oldest.voltage_average)
                    begin
                        $display("%0t: voltage_average expected %0d, actual %0d",
                                 $time, oldest.voltage_average, averages.voltage_average);
                        errors++;
                    end
                    if (averages.current_average !== oldest.current_average)
                    begin
                        $display("%0t: current_average expected %0d, actual %0d",
                                 $time, oldest.current_average, averages.current_average);
                        errors++;
                    end
                end
            end
            fail_count    <= fail_count + errors;
            pending_count <= expected_averages.size();
        end
    end

endmodule

@@ verif/dual_channel_moving_average_test.sv @@
// stimulus, handshake pacing and verdict for the dual channel moving average
`timescale 1ns / 1ps
module dual_channel_moving_average_test;
    import dcma_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;

    // sender idle and receiver stall odds per phase
    localparam int IDLE_PCT  [4] = '{0, 76, 0, 6};
    localparam int STALL_PCT [4] = '{0, 0, 76, 6};

    // voltage in the upper half, current in the lower half
    localparam logic [2*SAMPLE_W-1:0] DIRECTED_PAIRS [20] = '{
        24'h000_000, 24'hFFF_FFF, 24'hFFF_000, 24'h000_FFF, 24'hAAA_555,
        24'h555_AAA, 24'h800_7FF, 24'h7FF_800, 24'h001_001, 24'hFFE_002,
        24'h002_FFE, 24'h000_000, 24'hFFF_FFF, 24'h0F0_F0F, 24'hF0F_0F0,
        24'h064_063, 24'hFFF_001, 24'h001_FFF, 24'h000_000, 24'hFFF_FFF
    };

    logic        clk = 1'b0;
    logic        rst_n;
    int          sender_idle_pct;
    int          receiver_stall_pct;
    int unsigned cycle_count = 0;
    int          fail_count;
    int          pending_count;
    int          request_count;
    int          result_count;
    logic [SAMPLE_W-1:0] voltage_level;
    logic [SAMPLE_W-1:0] current_level;

    dcma_sample_if  sample_ch ();
    dcma_average_if average_ch ();

    dual_channel_moving_average i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (sample_ch),
        .averages (average_ch)
    );

    dcma_window_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .samples       (sample_ch),
        .averages      (average_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .request_count (request_count),
        .result_count  (result_count)
    );

    always
    begin
        #(CLK_HALF);
        clk = ~clk;
    end

    always @(posedge clk)
    begin
        average_ch.ready <= rst_n && ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d average pairs outstanding",
                     cycle_count, pending_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_pair(input logic [SAMPLE_W-1:0] voltage,
                             input logic [SAMPLE_W-1:0] current);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            // junk on the bus while idle must not be taken
            sample_ch.valid          <= 1'b0;
            sample_ch.voltage_sample <= SAMPLE_W'($urandom);
            sample_ch.current_sample <= SAMPLE_W'($urandom);
            @(posedge clk);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.voltage_sample <= voltage;
        sample_ch.current_sample <= current;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
    endtask

    // drifts around a level half the time, otherwise rail hits and full-range jumps
    function automatic logic [SAMPLE_W-1:0] wander(input logic [SAMPLE_W-1:0] level);
        int pick;
        int next;
        pick = $urandom_range(9);
        case (pick)
            0:       return '0;
            1:       return SAMPLE_W'(SAMPLE_MAX);
            2, 3, 4: return SAMPLE_W'($urandom_range(SAMPLE_MAX));
            default:
            begin
                next = int'(level) + int'($urandom_range(64)) - 32;
                if (next < 0) next = 0;
                if (next > SAMPLE_MAX) next = SAMPLE_MAX;
                return SAMPLE_W'(next);
            end
        endcase
    endfunction

    task automatic run_random(input int count);
        repeat (count)
        begin
            if ($urandom_range(99) < 3) voltage_level = SAMPLE_W'($urandom_range(SAMPLE_MAX));
            if ($urandom_range(99) < 3) current_level = SAMPLE_W'($urandom_range(SAMPLE_MAX));
            send_pair(wander(voltage_level), wander(current_level));
        end
    endtask

    initial
    begin
        rst_n                    <= 1'b0;
        sample_ch.valid          <= 1'b0;
        sample_ch.voltage_sample <= '0;
        sample_ch.current_sample <= '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        voltage_level      = SAMPLE_W'($urandom_range(SAMPLE_MAX));
        current_level      = SAMPLE_W'($urandom_range(SAMPLE_MAX));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // warm-up with zeros still in the windows, rails and bit patterns
        foreach (DIRECTED_PAIRS[i])
            send_pair(DIRECTED_PAIRS[i][2*SAMPLE_W-1:SAMPLE_W], DIRECTED_PAIRS[i][SAMPLE_W-1:0]);

        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct    = IDLE_PCT[phase];
            receiver_stall_pct = STALL_PCT[phase];
            // fill a whole window at full scale on one channel, floor on the other
            if (phase == 0)
                repeat (WINDOW + 10) send_pair(SAMPLE_W'(SAMPLE_MAX), '0);
            if (phase == 2)
                repeat (WINDOW + 10) send_pair('0, SAMPLE_W'(SAMPLE_MAX));
            run_random((phase == 0 || phase == 2) ? 65 : 175);
        end
        sample_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d sample pairs, checked %0d average pairs over four pacing phases",
                 request_count, result_count);
        $display("included warm-up, rail patterns and full-scale windows on both channels");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/dcma_pkg.sv
hdl/dcma_sample_if.sv
hdl/dcma_average_if.sv
hdl/dcma_ram.sv
hdl/dcma_ring.sv
hdl/dcma_div.sv
hdl/dcma_fifo.sv
hdl/dual_channel_moving_average.sv
verif/dcma_window_checker.sv
verif/dual_channel_moving_average_test.sv
